// File: sv/sbd_pkg.sv
// ---------------------------------------------------------------------------
// sbd_pkg
// Shared types, character codes and sizes of the sentence boundary detector.
// ---------------------------------------------------------------------------
`default_nettype none

package sbd_pkg;

    localparam int CHAR_BITS           = 8;
    localparam int DOC_BITS            = 16;
    localparam int OUT_BITS            = 32;
    localparam int OFFSET_BITS_DEFAULT = 32;
    localparam int TOKEN_COUNT_SAT     = 5;
    localparam int ABBREV_MAX_CHARS    = 4;
    localparam int COUNT_BITS          = 3;
    localparam int QUEUE_DEPTH         = 2;

    localparam logic [CHAR_BITS-1:0] CHAR_SPACE    = 8'h20;
    localparam logic [CHAR_BITS-1:0] CHAR_TAB      = 8'h09;
    localparam logic [CHAR_BITS-1:0] CHAR_CR       = 8'h0D;
    localparam logic [CHAR_BITS-1:0] CHAR_PERIOD   = 8'h2E;
    localparam logic [CHAR_BITS-1:0] CHAR_BANG     = 8'h21;
    localparam logic [CHAR_BITS-1:0] CHAR_QUERY    = 8'h3F;
    localparam logic [CHAR_BITS-1:0] CHAR_UPPER_A  = 8'h41;
    localparam logic [CHAR_BITS-1:0] CHAR_UPPER_Z  = 8'h5A;
    localparam logic [CHAR_BITS-1:0] CHAR_LOWER_A  = 8'h61;
    localparam logic [CHAR_BITS-1:0] CHAR_LOWER_Z  = 8'h7A;

    typedef enum logic [1:0] {
        TERM_NONE,
        TERM_PERIOD,
        TERM_BANG,
        TERM_QUERY
    } term_class_t;

    // One classified byte as it travels from the front end to the back end.
    typedef struct packed {
        logic        is_space;
        logic        is_upper;
        logic        is_lower;
        term_class_t term;
        logic        last;
    } sbd_item_t;

    function automatic term_class_t classify_term(logic [CHAR_BITS-1:0] c);
        term_class_t t;
        case (c)
            CHAR_PERIOD: t = TERM_PERIOD;
            CHAR_BANG:   t = TERM_BANG;
            CHAR_QUERY:  t = TERM_QUERY;
            default:     t = TERM_NONE;
        endcase
        return t;
    endfunction

endpackage

`default_nettype wire

// File: sv/sbd_text_if.sv
// ---------------------------------------------------------------------------
// sbd_text_if
// Byte stream channel: one text byte and its end-of-document mark.
// ---------------------------------------------------------------------------
`default_nettype none

interface sbd_text_if;

    logic                           valid;
    logic                           ready;
    logic [sbd_pkg::CHAR_BITS-1:0]  char_byte;
    logic                           last_byte;

    modport source (output valid, output char_byte, output last_byte, input ready);
    modport sink   (input valid, input char_byte, input last_byte, output ready);

endinterface

`default_nettype wire

// File: sv/sbd_sentence_if.sv
// ---------------------------------------------------------------------------
// sbd_sentence_if
// Sentence channel: document number, start offset and length of a sentence.
// ---------------------------------------------------------------------------
`default_nettype none

interface sbd_sentence_if;

    logic                           valid;
    logic                           ready;
    logic [sbd_pkg::DOC_BITS-1:0]   sentence_doc;
    logic [sbd_pkg::OUT_BITS-1:0]   sentence_start;
    logic [sbd_pkg::OUT_BITS-1:0]   sentence_length;

    modport source (output valid, output sentence_doc, output sentence_start,
                    output sentence_length, input ready);
    modport sink   (input valid, input sentence_doc, input sentence_start,
                    input sentence_length, output ready);

endinterface

`default_nettype wire

// File: sv/sbd_front.sv
// ---------------------------------------------------------------------------
// sbd_front
// Front end: accepts text bytes and classifies them for the back end.
// ---------------------------------------------------------------------------
`default_nettype none

module sbd_front
(
    sbd_text_if.sink             text,
    input  logic                 full,
    output logic                 push,
    output sbd_pkg::sbd_item_t   push_item
);

    logic [sbd_pkg::CHAR_BITS-1:0] c;

    assign c          = text.char_byte;
    assign text.ready = !full;
    assign push       = text.valid && !full;

    always_comb
    begin
        push_item.is_space = (c == sbd_pkg::CHAR_SPACE) ||
                             ((c >= sbd_pkg::CHAR_TAB) && (c <= sbd_pkg::CHAR_CR));
        push_item.is_upper = (c >= sbd_pkg::CHAR_UPPER_A) && (c <= sbd_pkg::CHAR_UPPER_Z);
        push_item.is_lower = (c >= sbd_pkg::CHAR_LOWER_A) && (c <= sbd_pkg::CHAR_LOWER_Z);
        push_item.term     = sbd_pkg::classify_term(c);
        push_item.last     = text.last_byte;
    end

endmodule

`default_nettype wire

// File: sv/sbd_fifo.sv
// ---------------------------------------------------------------------------
// sbd_fifo
// Short queue of classified bytes between the front end and the back end.
// ---------------------------------------------------------------------------
`default_nettype none

module sbd_fifo
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  sbd_pkg::sbd_item_t   push_item,
    output logic                 full,
    input  logic                 pop,
    output logic                 pop_valid,
    output sbd_pkg::sbd_item_t   pop_item
);

    localparam int DEPTH  = sbd_pkg::QUEUE_DEPTH;
    localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    sbd_pkg::sbd_item_t queue_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_item  = queue_reg[rd_ptr_reg];
    assign do_pop    = pop && pop_valid;

    function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// File: sv/sbd_back.sv
// ---------------------------------------------------------------------------
// sbd_back
// Back end: tracks tokens and candidates, decides boundaries, holds results.
// ---------------------------------------------------------------------------
`default_nettype none

module sbd_back
#(
    parameter int OFFSET_BITS = sbd_pkg::OFFSET_BITS_DEFAULT
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    input  sbd_pkg::sbd_item_t            item,
    output logic                          pop,
    input  logic [sbd_pkg::DOC_BITS-1:0]  doc_number,
    sbd_sentence_if.source                sentence
);

    localparam int CB = sbd_pkg::COUNT_BITS;
    localparam int OB = sbd_pkg::OUT_BITS;

    typedef logic [OFFSET_BITS-1:0] ofs_t;

    ofs_t                  joff_reg, joff_next;
    ofs_t                  start_reg, start_next;
    ofs_t                  cend_reg, cend_next;
    logic                  inside_reg, inside_next;
    logic [CB-1:0]         cnt_reg, cnt_next;
    logic                  cap_reg, cap_next;
    sbd_pkg::term_class_t  term_reg, term_next;
    logic                  pend_reg, pend_next;
    logic                  per_reg, per_next;
    logic                  shortcap_reg, shortcap_next;

    logic                  out_valid_reg, out_valid_next;
    logic [sbd_pkg::DOC_BITS-1:0] out_doc_reg;
    logic [OB-1:0]         out_start_reg, out_len_reg;

    logic                  emit;
    ofs_t                  emit_start, emit_len;
    logic                  abbrev;

    function automatic ofs_t sat_inc(ofs_t v);
        return (v == {OFFSET_BITS{1'b1}}) ? v : v + ofs_t'(1);
    endfunction

    function automatic logic [OB-1:0] clamp_out(ofs_t v);
        logic [63:0] wide;
        wide = 64'(v);
        return (wide > 64'({OB{1'b1}})) ? {OB{1'b1}} : wide[OB-1:0];
    endfunction

    // hold a byte only when it would overwrite a sentence still waiting
    assign pop = item_valid && (!emit || !out_valid_reg || sentence.ready);

    always_comb
    begin
        joff_next     = joff_reg;
        start_next    = start_reg;
        cend_next     = cend_reg;
        inside_next   = inside_reg;
        cnt_next      = cnt_reg;
        cap_next      = cap_reg;
        term_next     = term_reg;
        pend_next     = pend_reg;
        per_next      = per_reg;
        shortcap_next = shortcap_reg;
        emit          = 1'b0;
        emit_start    = start_reg;
        emit_len      = '0;
        abbrev        = 1'b0;

        // drop a candidate that an earlier sentence already covers
        if (start_next > cend_next)
        begin
            pend_next = 1'b0;
        end

        if (!item.is_space)
        begin
            if (!inside_next)
            begin
                abbrev = per_next && (item.is_lower || (shortcap_next && item.is_upper));
                if (pend_next)
                begin
                    if (!abbrev)
                    begin
                        emit       = 1'b1;
                        emit_start = start_next;
                        emit_len   = cend_next - start_next;
                        start_next = sat_inc(cend_next);
                    end
                    pend_next = 1'b0;
                end
                inside_next = 1'b1;
                cnt_next    = '0;
                cap_next    = item.is_upper;
            end
            if (cnt_next < CB'(sbd_pkg::TOKEN_COUNT_SAT))
            begin
                cnt_next = cnt_next + CB'(1);
            end
            term_next = item.term;
            joff_next = sat_inc(joff_next);
        end

        // close the token on whitespace or at end of document
        if (inside_next && (item.is_space || item.last))
        begin
            if (term_next != sbd_pkg::TERM_NONE)
            begin
                pend_next     = 1'b1;
                per_next      = (term_next == sbd_pkg::TERM_PERIOD);
                shortcap_next = cap_next && (cnt_next <= CB'(sbd_pkg::ABBREV_MAX_CHARS));
                cend_next     = joff_next;
            end
            joff_next   = sat_inc(joff_next);
            inside_next = 1'b0;
        end

        if (item.last)
        begin
            if (pend_next && !emit)
            begin
                emit       = 1'b1;
                emit_start = start_next;
                emit_len   = cend_next - start_next;
            end
            joff_next     = '0;
            start_next    = '0;
            cend_next     = '0;
            inside_next   = 1'b0;
            cnt_next      = '0;
            cap_next      = 1'b0;
            term_next     = sbd_pkg::TERM_NONE;
            pend_next     = 1'b0;
            per_next      = 1'b0;
            shortcap_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop && emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (sentence.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            joff_reg      <= '0;
            start_reg     <= '0;
            cend_reg      <= '0;
            inside_reg    <= 1'b0;
            cnt_reg       <= '0;
            cap_reg       <= 1'b0;
            term_reg      <= sbd_pkg::TERM_NONE;
            pend_reg      <= 1'b0;
            per_reg       <= 1'b0;
            shortcap_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                joff_reg     <= joff_next;
                start_reg    <= start_next;
                cend_reg     <= cend_next;
                inside_reg   <= inside_next;
                cnt_reg      <= cnt_next;
                cap_reg      <= cap_next;
                term_reg     <= term_next;
                pend_reg     <= pend_next;
                per_reg      <= per_next;
                shortcap_reg <= shortcap_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && emit)
        begin
            out_doc_reg   <= doc_number;
            out_start_reg <= clamp_out(emit_start);
            out_len_reg   <= clamp_out(emit_len);
        end
    end

    assign sentence.valid           = out_valid_reg;
    assign sentence.sentence_doc    = out_doc_reg;
    assign sentence.sentence_start  = out_start_reg;
    assign sentence.sentence_length = out_len_reg;

`ifndef SYNTHESIS
    a_result_from_item: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(pop))
        else $error("sentence appeared without a consumed byte");

    a_doc_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && item.last) |=> (!inside_reg && !pend_reg && (joff_reg == '0)))
        else $error("document state not cleared after last byte");

    a_token_counted: assert property (@(posedge clk) disable iff (!rst_n)
        inside_reg |-> (cnt_reg != '0))
        else $error("open token with zero byte count");
`endif

endmodule

`default_nettype wire

// File: sv/sentence_boundary_detector.sv
// ---------------------------------------------------------------------------
// sentence_boundary_detector
// Splits a byte stream into sentences and reports their joined-text spans.
// ---------------------------------------------------------------------------
// The block takes one text byte per clock cycle unless the back end holds a
// byte that would produce a sentence while the last one still waits in the
// output register. A byte passes through a two-entry queue and the back-end
// state update, and the sentence that it decides is written to the output
// register when the back end takes that byte. A sentence waiting in the
// output register does not stop the next byte from being processed unless
// that byte also produces a sentence. There is no clearing pass after reset.
// ---------------------------------------------------------------------------
`default_nettype none

module sentence_boundary_detector
#(
    parameter int OFFSET_BITS = sbd_pkg::OFFSET_BITS_DEFAULT
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wr_en,
    input  wire logic [sbd_pkg::DOC_BITS-1:0]  cfg_wr_data,
    sbd_text_if.sink                           text,
    sbd_sentence_if.source                     sentence
);

    logic [sbd_pkg::DOC_BITS-1:0] doc_number_reg, doc_number_next;

    logic                 push;
    sbd_pkg::sbd_item_t   push_item;
    logic                 full;
    logic                 pop;
    logic                 pop_valid;
    sbd_pkg::sbd_item_t   pop_item;

    assign doc_number_next = cfg_wr_en ? cfg_wr_data : doc_number_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            doc_number_reg <= '0;
        end
        else
        begin
            doc_number_reg <= doc_number_next;
        end
    end

    sbd_front u_front
    (
        .text      (text),
        .full      (full),
        .push      (push),
        .push_item (push_item)
    );

    sbd_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (full),
        .pop       (pop),
        .pop_valid (pop_valid),
        .pop_item  (pop_item)
    );

    sbd_back #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (pop_valid),
        .item       (pop_item),
        .pop        (pop),
        .doc_number (doc_number_reg),
        .sentence   (sentence)
    );

endmodule

`default_nettype wire

// File: bench/sbd_sentence_checker.sv
// ---------------------------------------------------------------------------
// sbd_sentence_checker
// Watches the byte and sentence channels of the sentence boundary detector.
// Every accepted byte runs through a cycle-free model of the token and
// candidate logic, and the sentences it yields are queued. Every accepted
// sentence is compared field by field with the oldest one in the queue.
// ---------------------------------------------------------------------------
`default_nettype none

module sbd_sentence_checker
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wr_en,
    input  wire logic [sbd_pkg::DOC_BITS-1:0]  cfg_wr_data,
    sbd_text_if                                text,
    sbd_sentence_if                            sentence,
    output int                                 fail_count,
    output int                                 sentences_owed
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          OFS_BITS = sbd_pkg::OFFSET_BITS_DEFAULT;
    localparam logic [63:0] OFS_MAX  = {64{1'b1}} >> (64 - OFS_BITS);
    localparam logic [63:0] OUT_MAX  = (64'd1 << sbd_pkg::OUT_BITS) - 64'd1;

    typedef struct packed {
        logic [sbd_pkg::DOC_BITS-1:0] doc;
        logic [sbd_pkg::OUT_BITS-1:0] start;
        logic [sbd_pkg::OUT_BITS-1:0] length;
    } sentence_t;

    sentence_t                    expected_sentences[$];
    logic [sbd_pkg::DOC_BITS-1:0] doc_number;
    logic [63:0]                  joined_ofs;
    logic [63:0]                  sent_start;
    logic [63:0]                  cand_end;
    bit                           in_token;
    bit                           tok_capital;
    int unsigned                  tok_chars;
    sbd_pkg::term_class_t         tok_term;
    bit                           cand_pending;
    bit                           cand_period;
    bit                           cand_short_cap;

    initial fail_count = 0;

    function automatic logic [63:0] bump(input logic [63:0] v);
        return (v >= OFS_MAX) ? OFS_MAX : v + 64'd1;
    endfunction

    function automatic logic [sbd_pkg::OUT_BITS-1:0] clip(input logic [63:0] v);
        return (v > OUT_MAX) ? OUT_MAX[sbd_pkg::OUT_BITS-1:0] : v[sbd_pkg::OUT_BITS-1:0];
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns sentence check: %s", $realtime, msg);
        fail_count++;
    endtask

    task automatic clear_document();
        joined_ofs     = '0;
        sent_start     = '0;
        cand_end       = '0;
        in_token       = 1'b0;
        tok_capital    = 1'b0;
        tok_chars      = 0;
        tok_term       = sbd_pkg::TERM_NONE;
        cand_pending   = 1'b0;
        cand_period    = 1'b0;
        cand_short_cap = 1'b0;
    endtask

    task automatic close_token();
        if (tok_term != sbd_pkg::TERM_NONE)
        begin
            cand_pending   = 1'b1;
            cand_period    = (tok_term == sbd_pkg::TERM_PERIOD);
            cand_short_cap = tok_capital && (tok_chars <= sbd_pkg::ABBREV_MAX_CHARS);
            cand_end       = joined_ofs;
        end
        // the joining space after the token
        joined_ofs = bump(joined_ofs);
        in_token   = 1'b0;
    endtask

    task automatic emit_sentence();
        sentence_t s;
        s.doc    = doc_number;
        s.start  = clip(sent_start);
        s.length = clip(cand_end - sent_start);
        expected_sentences = {expected_sentences, s};
        sent_start   = bump(cand_end);
        cand_pending = 1'b0;
    endtask

    task automatic take_byte(input logic [sbd_pkg::CHAR_BITS-1:0] c, input logic last_mark);
        bit                   is_blank;
        bit                   is_cap;
        bit                   is_small;
        bit                   emitted;
        bit                   abbrev;
        sbd_pkg::term_class_t term;
        is_blank = (c == sbd_pkg::CHAR_SPACE) ||
                   (c >= sbd_pkg::CHAR_TAB && c <= sbd_pkg::CHAR_CR);
        is_cap   = (c >= sbd_pkg::CHAR_UPPER_A) && (c <= sbd_pkg::CHAR_UPPER_Z);
        is_small = (c >= sbd_pkg::CHAR_LOWER_A) && (c <= sbd_pkg::CHAR_LOWER_Z);
        term     = (c == sbd_pkg::CHAR_PERIOD) ? sbd_pkg::TERM_PERIOD :
                   (c == sbd_pkg::CHAR_BANG)   ? sbd_pkg::TERM_BANG   :
                   (c == sbd_pkg::CHAR_QUERY)  ? sbd_pkg::TERM_QUERY  : sbd_pkg::TERM_NONE;
        emitted  = 1'b0;
        // only reachable once offsets have saturated
        if (cand_pending && sent_start > cand_end)
            cand_pending = 1'b0;
        if (is_blank)
        begin
            if (in_token)
                close_token();
        end
        else
        begin
            if (!in_token)
            begin
                // first byte of a token decides the pending candidate
                if (cand_pending)
                begin
                    abbrev = cand_period && (is_small || (cand_short_cap && is_cap));
                    if (abbrev)
                        cand_pending = 1'b0;
                    else
                    begin
                        emit_sentence();
                        emitted = 1'b1;
                    end
                end
                in_token    = 1'b1;
                tok_chars   = 0;
                tok_capital = is_cap;
            end
            if (tok_chars < sbd_pkg::TOKEN_COUNT_SAT)
                tok_chars++;
            tok_term   = term;
            joined_ofs = bump(joined_ofs);
        end
        if (last_mark)
        begin
            if (in_token)
                close_token();
            // one sentence per byte at most: drop the final one if another left
            if (cand_pending && !emitted)
                emit_sentence();
            clear_document();
        end
    endtask

    task automatic check_sentence();
        sentence_t want;
        if (expected_sentences.size() == 0)
        begin
            report_mismatch($sformatf("unexpected sentence doc %h start %0d length %0d",
                                      sentence.sentence_doc, sentence.sentence_start,
                                      sentence.sentence_length));
        end
        else
        begin
            want = expected_sentences.pop_front();
            if (sentence.sentence_doc !== want.doc)
                report_mismatch($sformatf("doc %h, want %h",
                                          sentence.sentence_doc, want.doc));
            if (sentence.sentence_start !== want.start)
                report_mismatch($sformatf("start %0d, want %0d",
                                          sentence.sentence_start, want.start));
            if (sentence.sentence_length !== want.length)
                report_mismatch($sformatf("length %0d, want %0d",
                                          sentence.sentence_length, want.length));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            doc_number = '0;
            clear_document();
            expected_sentences.delete();
        end
        else
        begin
            if (sentence.valid && sentence.ready)
                check_sentence();
            if (cfg_wr_en)
                doc_number = cfg_wr_data;
            if (text.valid && text.ready)
                take_byte(text.char_byte, text.last_byte);
        end
        sentences_owed = expected_sentences.size();
    end

endmodule

`default_nettype wire

// File: bench/tb.sv
// ---------------------------------------------------------------------------
// tb
// Stimulus and verdict for the sentence boundary detector.
// A short directed text covers abbreviations, boundaries, odd bytes and the
// final-byte cases; then random documents built from words, abbreviations,
// terminators, noise and mixed whitespace run under several document numbers,
// with random gaps on the byte side and random stalls on the sentence side.
// ---------------------------------------------------------------------------
`default_nettype none

module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT   = 2000;
    localparam int RANDOM_ITEMS = 1150;
    localparam int PHASES       = 5;
    localparam int DRAIN_CYCLES = 8;

    localparam logic [sbd_pkg::CHAR_BITS-1:0] ODD_BYTES [12] = '{
        8'h00, 8'h08, 8'h0E, 8'h1F, 8'h40, 8'h5B,
        8'h60, 8'h7B, 8'h7F, 8'h80, 8'hC3, 8'hFF
    };

    logic                         clk;
    logic                         rst_n;
    logic                         cfg_wr_en;
    logic [sbd_pkg::DOC_BITS-1:0] cfg_wr_data;
    int                           fail_count;
    int                           sentences_owed;
    int                           bytes_sent;
    int                           sentences_taken;
    int                           idle_cycles;
    bit                           send_burst;
    bit                           take_burst;
    logic [sbd_pkg::CHAR_BITS-1:0] doc_bytes[$];

    sbd_text_if     text_ch();
    sbd_sentence_if sentence_ch();

    sentence_boundary_detector u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .text        (text_ch),
        .sentence    (sentence_ch)
    );

    sbd_sentence_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .text           (text_ch),
        .sentence       (sentence_ch),
        .fail_count     (fail_count),
        .sentences_owed (sentences_owed)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic logic [sbd_pkg::CHAR_BITS-1:0] pick_space();
        return ($urandom_range(0, 2) != 0) ? sbd_pkg::CHAR_SPACE
                                           : sbd_pkg::CHAR_TAB + 8'($urandom_range(0, 4));
    endfunction

    function automatic logic [sbd_pkg::CHAR_BITS-1:0] pick_letter(input bit capital);
        return capital ? sbd_pkg::CHAR_UPPER_A + 8'($urandom_range(0, 25))
                       : sbd_pkg::CHAR_LOWER_A + 8'($urandom_range(0, 25));
    endfunction

    function automatic logic [sbd_pkg::CHAR_BITS-1:0] pick_term();
        case ($urandom_range(0, 4))
            3:       return sbd_pkg::CHAR_BANG;
            4:       return sbd_pkg::CHAR_QUERY;
            default: return sbd_pkg::CHAR_PERIOD;
        endcase
    endfunction

    function automatic logic [sbd_pkg::CHAR_BITS-1:0] pick_odd_byte();
        return ($urandom_range(0, 2) == 0) ? ODD_BYTES[$urandom_range(0, 11)]
                                           : 8'($urandom_range(0, 255));
    endfunction

    function automatic void add_byte(input logic [sbd_pkg::CHAR_BITS-1:0] b);
        doc_bytes = {doc_bytes, b};
    endfunction

    // Call at a falling edge; returns at the falling edge after acceptance.
    task automatic put_byte(input logic [sbd_pkg::CHAR_BITS-1:0] c, input bit mark_last);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            text_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        text_ch.valid     <= 1'b1;
        text_ch.char_byte <= c;
        text_ch.last_byte <= mark_last;
        do
            @(posedge clk);
        while (text_ch.ready !== 1'b1);
        @(negedge clk);
        bytes_sent++;
    endtask

    task automatic write_doc_number(input logic [sbd_pkg::DOC_BITS-1:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic send_document();
        int n_tokens;
        int len;
        int kind;
        doc_bytes.delete();
        send_burst = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 19) == 0)
        begin
            // raw noise
            len = $urandom_range(1, 20);
            repeat (len) add_byte(8'($urandom_range(0, 255)));
        end
        else
        begin
            if ($urandom_range(0, 4) == 0)
                add_byte(pick_space());
            n_tokens = $urandom_range(1, 10);
            for (int t = 0; t < n_tokens; t++)
            begin
                if (t > 0)
                begin
                    add_byte(pick_space());
                    if ($urandom_range(0, 4) == 0)
                        add_byte(pick_space());
                end
                kind = $urandom_range(0, 9);
                if (kind <= 6)
                begin
                    // word; kind 6 is a capitalized abbreviation of 2..6 bytes
                    len = (kind == 6) ? $urandom_range(0, 4) : $urandom_range(0, 6);
                    add_byte(pick_letter(kind == 6 || $urandom_range(0, 1) != 0));
                    repeat (len) add_byte(pick_letter($urandom_range(0, 3) == 0));
                    if (kind == 6)
                        add_byte(sbd_pkg::CHAR_PERIOD);
                    else if ($urandom_range(0, 1) != 0)
                        add_byte(pick_term());
                end
                else if (kind == 7)
                begin
                    len = $urandom_range(1, 4);
                    repeat (len) add_byte(pick_odd_byte());
                    if ($urandom_range(0, 1) != 0)
                        add_byte(pick_term());
                end
                else if (kind == 8)
                    add_byte(pick_term());
                else
                begin
                    add_byte(8'($urandom_range(8'h21, 8'h40)));
                    add_byte(pick_term());
                end
            end
            // vary how the document ends
            case ($urandom_range(0, 3))
                1:
                begin
                    add_byte(pick_space());
                end
                2:
                begin
                    add_byte(pick_space());
                    add_byte(pick_term());
                end
                3:
                begin
                    add_byte(pick_space());
                    add_byte(pick_letter($urandom_range(0, 1) != 0));
                    add_byte(pick_letter(1'b0));
                end
                default:
                begin
                end
            endcase
        end
        foreach (doc_bytes[i])
            put_byte(doc_bytes[i], i == doc_bytes.size() - 1);
    endtask

    // Sentence side: stall for a drawn number of cycles, then take one request.
    initial
    begin
        int stall;
        take_burst = 1'b0;
        forever
        begin
            stall = take_burst ? 0 : $urandom_range(0, 16);
            if (stall > 0)
            begin
                sentence_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            sentence_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (sentence_ch.valid !== 1'b1);
            @(negedge clk);
            sentences_taken++;
            if (sentences_taken % 20 == 0)
                take_burst = ($urandom_range(0, 2) == 0);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (text_ch.valid && text_ch.ready) ||
            (sentence_ch.valid && sentence_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        string intro;
        int    target;
        rst_n             <= 1'b0;
        cfg_wr_en         <= 1'b0;
        cfg_wr_data       <= '0;
        text_ch.valid     <= 1'b0;
        text_ch.char_byte <= '0;
        text_ch.last_byte <= 1'b0;
        send_burst = 1'b0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        write_doc_number(16'($urandom_range(1, 16'hFFFE)));

        // short capital and lower-case abbreviations, a long capital token,
        // a vertical tab, and a final lone terminator after a boundary
        intro = "Mr. Hi. no.\013Abcde. X! ?";
        for (int i = 0; i < intro.len(); i++)
            put_byte(intro[i], i == intro.len() - 1);
        // non-ASCII and NUL tokens, form feed, end on a carriage return
        put_byte(8'hFF, 1'b0);
        put_byte(sbd_pkg::CHAR_PERIOD, 1'b0);
        put_byte(8'h0C, 1'b0);
        put_byte(8'h00, 1'b0);
        put_byte(sbd_pkg::CHAR_BANG, 1'b0);
        put_byte(sbd_pkg::CHAR_CR, 1'b1);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            // drop the byte request and drain before touching the document number
            text_ch.valid <= 1'b0;
            while (sentences_owed != 0)
                @(negedge clk);
            repeat (DRAIN_CYCLES) @(negedge clk);
            case (phase)
                0:       write_doc_number('1);
                1:       write_doc_number('0);
                default: write_doc_number(16'($urandom_range(0, 16'hFFFF)));
            endcase
            target = bytes_sent + RANDOM_ITEMS / PHASES;
            while (bytes_sent < target)
                send_document();
        end
        text_ch.valid <= 1'b0;

        while (sentences_owed != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire

// File: sim.f
sv/sbd_pkg.sv
sv/sbd_text_if.sv
sv/sbd_sentence_if.sv
sv/sbd_front.sv
sv/sbd_fifo.sv
sv/sbd_back.sv
sv/sentence_boundary_detector.sv
bench/sbd_sentence_checker.sv
bench/tb.sv
